// ----- rtl/polyphonic_sine_voice_mixer_core_macros.svh -----
// Assertion macros for the voice mixer core
`ifndef POLYPHONIC_SINE_VOICE_MIXER_CORE_MACROS_SVH
`define POLYPHONIC_SINE_VOICE_MIXER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PSVM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psvm assertion failed");
`define PSVM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psvm assertion failed");
`else
`define PSVM_ASSERT_SAME(label, ante, cons)
`define PSVM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/psvm_pkg.sv -----
package psvm_pkg;

    localparam int NUM_VOICES_DEF      = 32;
    localparam int PHASE_BITS_DEF      = 24;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int AMP_W    = 16;
    localparam int DUR_W    = 20;
    localparam int FRAMES_W = 20;
    localparam int STEP_W   = 23;
    localparam int VI_W     = 5;
    localparam int REQ_W    = 2;
    localparam int SINE_W   = 15;
    localparam int MAG_W    = AMP_W + SINE_W;
    localparam int PROD_W   = MAG_W + FRAMES_W;
    localparam int SAMPLE_W = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_ON = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd2;

    localparam logic REG_AMPLITUDE = 1'b0;
    localparam logic REG_DURATION  = 1'b1;

    localparam logic [AMP_W-1:0] AMP_RESET = 16'd13107;
    localparam logic [DUR_W-1:0] DUR_RESET = 20'd44100;

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [VI_W-1:0]   voice_index;
        logic [STEP_W-1:0] phase_increment;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } rsp_t;

    typedef struct packed {
        logic phase;
        logic frames;
        logic step;
    } vs_we_t;

    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
                                                     input int unsigned stb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned h;
        longint unsigned s;
        longint unsigned v;
        x  = (PI_HALF_Q30 * 64'(k)) >> stb;
        x2 = (x * x) >> 30;
        h  = Q30_ONE - x2 / 64'd110;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd72;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd42;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd20;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd6;
        s  = (x * h) >> 30;
        v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

// ----- rtl/psvm_voice_store.sv -----
module psvm_voice_store
    import psvm_pkg::*;
#(
    parameter int NUM_VOICES = NUM_VOICES_DEF,
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int VA_W       = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [VA_W-1:0]       rd_addr,
    output logic [PHASE_BITS-1:0] rd_phase,
    output logic [FRAMES_W-1:0]   rd_frames,
    output logic [STEP_W-1:0]     rd_step,
    input  vs_we_t                wr_en,
    input  logic [VA_W-1:0]       wr_addr,
    input  logic [PHASE_BITS-1:0] wr_phase,
    input  logic [FRAMES_W-1:0]   wr_frames,
    input  logic [STEP_W-1:0]     wr_step
);

    logic [PHASE_BITS-1:0] phase_mem  [NUM_VOICES];
    logic [FRAMES_W-1:0]   frames_mem [NUM_VOICES];
    logic [STEP_W-1:0]     step_mem   [NUM_VOICES];

    logic [NUM_VOICES-1:0] phase_vld_reg;
    logic [NUM_VOICES-1:0] frames_vld_reg;
    logic [NUM_VOICES-1:0] step_vld_reg;

    logic [PHASE_BITS-1:0] phase_q_reg;
    logic [FRAMES_W-1:0]   frames_q_reg;
    logic [STEP_W-1:0]     step_q_reg;
    logic                  phase_v_reg;
    logic                  frames_v_reg;
    logic                  step_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_vld_reg  <= '0;
            frames_vld_reg <= '0;
            step_vld_reg   <= '0;
        end
        else
        begin
            if (wr_en.phase)
            begin
                phase_vld_reg[wr_addr] <= 1'b1;
            end
            if (wr_en.frames)
            begin
                frames_vld_reg[wr_addr] <= 1'b1;
            end
            if (wr_en.step)
            begin
                step_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en.phase)
        begin
            phase_mem[wr_addr] <= wr_phase;
        end
        if (wr_en.frames)
        begin
            frames_mem[wr_addr] <= wr_frames;
        end
        if (wr_en.step)
        begin
            step_mem[wr_addr] <= wr_step;
        end
        if (rd_en)
        begin
            phase_q_reg  <= phase_mem[rd_addr];
            frames_q_reg <= frames_mem[rd_addr];
            step_q_reg   <= step_mem[rd_addr];
            phase_v_reg  <= phase_vld_reg[rd_addr];
            frames_v_reg <= frames_vld_reg[rd_addr];
            step_v_reg   <= step_vld_reg[rd_addr];
        end
    end

    assign rd_phase  = phase_v_reg  ? phase_q_reg  : '0;
    assign rd_frames = frames_v_reg ? frames_q_reg : '0;
    assign rd_step   = step_v_reg   ? step_q_reg   : '0;

endmodule

// ----- rtl/psvm_sine_rom.sv -----
module psvm_sine_rom
    import psvm_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [SINE_TABLE_BITS:0] addr,
    output logic [SINE_W-1:0]        rdata
);

    localparam int QUARTER_LEN = 1 << SINE_TABLE_BITS;

    logic [SINE_W-1:0] tab [QUARTER_LEN + 1];
    logic [SINE_W-1:0] rdata_reg;

    for (genvar k = 0; k <= QUARTER_LEN; k++)
    begin : g_tab
        assign tab[k] = sine_entry(k, SINE_TABLE_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= tab[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/psvm_divider.sv -----
module psvm_divider
    import psvm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [DUR_W-1:0]  divisor,
    output logic              busy,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(PROD_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [DUR_W-1:0]  rem_reg;
    logic [DUR_W-1:0]  dsr_reg;
    logic [DUR_W:0]    shifted;
    logic [DUR_W:0]    trial;
    logic              take;

    assign shifted = {rem_reg, quo_reg[PROD_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign take    = !trial[DUR_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? trial[DUR_W-1:0] : shifted[DUR_W-1:0];
            quo_reg <= {quo_reg[PROD_W-2:0], take};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/polyphonic_sine_voice_mixer_core.sv -----
// Tick: each voice in turn is read in S_RD and S_ROM; a sounding voice then passes S_MUL1,
// S_MUL2, S_DIV and S_WAIT on the 51-step divider; rsp_valid rises from S_OUT, then idle.
// Note on and load: accepted only while no tick is in work.
// The result register holds a finished sample while the next item is taken.
// Reset (rst_n low, asynchronous): all voices silent with zero phase and step,
// amplitude 13107, duration 44100, no result pending.
`include "polyphonic_sine_voice_mixer_core_macros.svh"

module polyphonic_sine_voice_mixer_core
    import psvm_pkg::*;
#(
    parameter int NUM_VOICES      = NUM_VOICES_DEF,
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int VA_W  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int IDX_W = SINE_TABLE_BITS + 2;
    localparam int SUM_W = PROD_W + $clog2(NUM_VOICES + 1) + 2;
    localparam logic [VA_W-1:0] LAST_VOICE = VA_W'(NUM_VOICES - 1);
    localparam logic [SINE_TABLE_BITS:0] QUARTER_LEN = (SINE_TABLE_BITS + 1)'(1 << SINE_TABLE_BITS);
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << 16);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_ROM  = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_WAIT = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [VA_W-1:0]         vidx_reg;
    logic [VA_W-1:0]         vidx_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic                    neg_reg;
    logic [PROD_W-1:0]       mul_reg;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    rsp_t                    rsp_reg;
    logic [AMP_W-1:0]        amp_reg;
    logic [DUR_W-1:0]        dur_reg;

    logic                    cfg_wr;
    logic                    req_xfer;
    logic                    addr_ok;
    logic                    last_voice;
    logic                    out_free;

    logic                    st_rd_en;
    logic [PHASE_BITS-1:0]   st_phase;
    logic [FRAMES_W-1:0]     st_frames;
    logic [STEP_W-1:0]       st_step;
    vs_we_t                  st_we;
    logic [VA_W-1:0]         st_wr_addr;
    logic [PHASE_BITS-1:0]   st_wr_phase;
    logic [FRAMES_W-1:0]     st_wr_frames;

    logic [PHASE_BITS+IDX_W-1:0] phase_wide;
    logic [IDX_W-1:0]            sine_idx;
    logic [SINE_TABLE_BITS-1:0]  sine_off;
    logic [SINE_TABLE_BITS:0]    rom_addr;
    logic                        rom_rd_en;
    logic [SINE_W-1:0]           rom_data;

    logic [MAG_W-1:0]        mul_a;
    logic [FRAMES_W-1:0]     mul_b;

    logic                    div_start;
    logic                    div_busy;
    logic                    div_done;
    logic [PROD_W-1:0]       div_quo;
    logic [DUR_W-1:0]        divisor;
    logic signed [SUM_W-1:0] term;
    logic signed [SUM_W-1:0] rounded;
    logic signed [SUM_W-1:0] scaled;
    rsp_t                    rsp_calc;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign prdata    = (paddr[CFG_ADDR_W-1] == REG_DURATION) ? CFG_DATA_W'(dur_reg)
                                                             : CFG_DATA_W'(amp_reg);
    assign req_ready = (state_reg == S_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign addr_ok   = (32'(req.voice_index) < NUM_VOICES);
    assign last_voice = (vidx_reg == LAST_VOICE);
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg <= AMP_RESET;
            dur_reg <= DUR_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[CFG_ADDR_W-1] == REG_DURATION)
            begin
                dur_reg <= pwdata[DUR_W-1:0];
            end
            else
            begin
                amp_reg <= pwdata[AMP_W-1:0];
            end
        end
    end

    assign st_rd_en     = (state_reg == S_RD);
    assign st_wr_phase  = st_phase + PHASE_BITS'(st_step);
    assign st_wr_frames = (state_reg == S_IDLE) ? dur_reg : st_frames - 1'b1;
    assign st_wr_addr   = (state_reg == S_IDLE) ? VA_W'(req.voice_index) : vidx_reg;

    always_comb
    begin
        st_we = '0;
        if (req_xfer && addr_ok)
        begin
            st_we.frames = (req.req_type == REQ_NOTE_ON);
            st_we.step   = (req.req_type == REQ_LOAD);
        end
        if ((state_reg == S_ROM) && (st_frames != '0))
        begin
            st_we.phase  = 1'b1;
            st_we.frames = 1'b1;
        end
    end

    psvm_voice_store #(
        .NUM_VOICES (NUM_VOICES),
        .PHASE_BITS (PHASE_BITS),
        .VA_W       (VA_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (st_rd_en),
        .rd_addr   (vidx_reg),
        .rd_phase  (st_phase),
        .rd_frames (st_frames),
        .rd_step   (st_step),
        .wr_en     (st_we),
        .wr_addr   (st_wr_addr),
        .wr_phase  (st_wr_phase),
        .wr_frames (st_wr_frames),
        .wr_step   (req.phase_increment)
    );

    assign phase_wide = {st_phase, IDX_W'(0)};
    assign sine_idx   = phase_wide[PHASE_BITS +: IDX_W];
    assign sine_off   = sine_idx[SINE_TABLE_BITS-1:0];
    assign rom_addr   = sine_idx[SINE_TABLE_BITS] ? QUARTER_LEN - {1'b0, sine_off}
                                                  : {1'b0, sine_off};
    assign rom_rd_en  = (state_reg == S_ROM);

    psvm_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk   (clk),
        .rd_en (rom_rd_en),
        .addr  (rom_addr),
        .rdata (rom_data)
    );

    // one multiplier: amplitude times sine, then magnitude times frames left
    assign mul_a = (state_reg == S_MUL1) ? MAG_W'(amp_reg) : mul_reg[MAG_W-1:0];
    assign mul_b = (state_reg == S_MUL1) ? FRAMES_W'(rom_data) : st_frames;

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_MUL1) || (state_reg == S_MUL2))
        begin
            mul_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (state_reg == S_ROM)
        begin
            neg_reg <= sine_idx[SINE_TABLE_BITS+1];
        end
    end

    assign divisor   = (dur_reg == '0) ? DUR_W'(1) : dur_reg;
    assign div_start = (state_reg == S_DIV);

    psvm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_reg),
        .divisor  (divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign term    = neg_reg ? -SUM_W'(div_quo) : SUM_W'(div_quo);
    assign rounded = sum_reg + ROUND_HALF;
    assign scaled  = rounded >>> 17;

    always_comb
    begin
        rsp_calc.clipped = 1'b0;
        rsp_calc.sample  = scaled[SAMPLE_W-1:0];
        if (scaled > SAT_HI)
        begin
            rsp_calc.sample  = SAT_HI[SAMPLE_W-1:0];
            rsp_calc.clipped = 1'b1;
        end
        else if (scaled < SAT_LO)
        begin
            rsp_calc.sample  = SAT_LO[SAMPLE_W-1:0];
            rsp_calc.clipped = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        vidx_next      = vidx_reg;
        sum_next       = sum_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer && (req.req_type == REQ_TICK))
                begin
                    vidx_next  = '0;
                    sum_next   = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_ROM;
            end
            S_ROM:
            begin
                if (st_frames != '0)
                begin
                    state_next = S_MUL1;
                end
                else if (last_voice)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    vidx_next  = vidx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    sum_next = sum_reg + term;
                    if (last_voice)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        vidx_next  = vidx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vidx_reg <= vidx_next;
        sum_reg  <= sum_next;
        if ((state_reg == S_OUT) && out_free)
        begin
            rsp_reg <= rsp_calc;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `PSVM_ASSERT_SAME(a_rsp_from_out, $rose(rsp_valid), $past(state_reg) == S_OUT)
    `PSVM_ASSERT_SAME(a_div_idle_on_start, div_start, !div_busy)
    `PSVM_ASSERT_NEXT(a_tick_starts_walk, req_xfer && (req.req_type == REQ_TICK), state_reg == S_RD)
    `PSVM_ASSERT_SAME(a_done_only_waiting, div_done, state_reg == S_WAIT)

endmodule
